[rtl/bsfb_pkg.sv]
package bsfb_pkg;

    localparam int DATA_W   = 8;
    localparam int ORIGIN_W = 13;
    localparam int ADDR_W   = 19;
    localparam int COLOR_W  = 32;
    localparam int STATUS_W = 3;
    localparam int OFF_W    = 6;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y = 1'b1;

    localparam logic [DATA_W-1:0] SIG_LO = 8'h42;
    localparam logic [DATA_W-1:0] SIG_HI = 8'h4D;

    localparam logic [OFF_W-1:0] OFF_SIG        = 6'd1;
    localparam logic [OFF_W-1:0] OFF_WIDTH_END  = 6'h15;
    localparam logic [OFF_W-1:0] OFF_HEIGHT_END = 6'h19;
    localparam logic [OFF_W-1:0] OFF_DEPTH_END  = 6'h1D;
    localparam logic [OFF_W-1:0] HEADER_LAST    = 6'd53;

    localparam logic [15:0] DEPTH_24 = 16'd24;
    localparam logic [15:0] DEPTH_32 = 16'd32;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_NOT_BMP   = 3'd1,
        ST_BAD_DEPTH = 3'd2,
        ST_TOO_LARGE = 3'd3,
        ST_TRUNCATED = 3'd4
    } status_t;

endpackage

[rtl/bmp_stream_to_framebuffer_top.sv]
// Channel   Direction  Handshake            Payload
// -------   ---------  -------------------  -------------------------------------------
// in        input      in_valid / in_ready  data_byte, first_byte, last_byte
// out       output     out_valid/out_ready  pixel_valid, pixel_addr, pixel_color,
//                                           image_done, status
// cfg       input      cfg_write_en         cfg_index, cfg_data
//
// One byte per cycle sustained while the result is not stalled; a byte passes the input register and then
// the result register, which sit around the parse logic.
// A byte that causes no result still passes through the input register.
// rst_n clears the parser to idle, the origin registers to zero and both valid flags.
// A stalled result holds the input register; in_ready falls only when both stages are full.
module bmp_stream_to_framebuffer_top #(
    parameter int SCREEN_WIDTH  = 800,
    parameter int SCREEN_HEIGHT = 480,
    parameter int MAX_IMAGE_DIM = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [bsfb_pkg::DATA_W-1:0]       data_byte,
    input  logic                              first_byte,
    input  logic                              last_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              pixel_valid,
    output logic [bsfb_pkg::ADDR_W-1:0]       pixel_addr,
    output logic [bsfb_pkg::COLOR_W-1:0]      pixel_color,
    output logic                              image_done,
    output logic [bsfb_pkg::STATUS_W-1:0]     status,
    input  logic                              cfg_write_en,
    input  logic [bsfb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [bsfb_pkg::ORIGIN_W-1:0]     cfg_data
);
    import bsfb_pkg::*;

    localparam int DIM_W = $clog2(MAX_IMAGE_DIM + 1);
    localparam int MW    = (DIM_W > ORIGIN_W) ? DIM_W : ORIGIN_W;
    localparam int CW    = MW + 3;
    localparam int XW    = $clog2(SCREEN_WIDTH);
    localparam int YW    = $clog2(SCREEN_HEIGHT);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PIXELS,
        PH_DONE,
        PH_ERROR
    } phase_t;

    phase_t                    phase_reg, phase_next;
    logic [OFF_W-1:0]          off_reg, off_next;
    logic [31:0]               shift_reg, shift_next;
    logic [DIM_W-1:0]          w_mag_reg, w_mag_next;
    logic                      w_neg_reg, w_neg_next;
    logic                      w_big_reg, w_big_next;
    logic [DIM_W-1:0]          h_mag_reg, h_mag_next;
    logic                      h_neg_reg, h_neg_next;
    logic                      h_big_reg, h_big_next;
    logic                      d24_reg, d24_next;
    logic                      d32_reg, d32_next;
    logic                      alpha_en_reg, alpha_en_next;
    logic [DIM_W-1:0]          col_reg, col_next;
    logic [DIM_W-1:0]          row_reg, row_next;
    logic [1:0]                pad_reg, pad_next;
    logic [1:0]                bip_reg, bip_next;
    logic [23:0]               bgr_reg, bgr_next;

    logic signed [ORIGIN_W-1:0] origin_x_reg, origin_y_reg;

    logic                      s1_valid_reg;
    logic [DATA_W-1:0]         s1_byte_reg;
    logic                      s1_first_reg;
    logic                      s1_last_reg;

    logic                      out_valid_reg, out_valid_next;
    logic                      pix_valid_reg, pix_valid_next;
    logic [ADDR_W-1:0]         addr_reg, addr_next;
    logic [COLOR_W-1:0]        color_reg, color_next;
    logic                      done_reg, done_next;
    status_t                   status_reg, status_next;

    logic                      advance;
    logic                      process;
    logic                      have;

    logic [31:0]               mag32;
    logic                      big;
    logic [DIM_W-1:0]          col_inc, row_inc;
    logic [CW-1:0]             sx, sy;
    logic                      on_screen;
    logic [31:0]               lin_addr;
    logic [23:0]               bgr_upd;
    logic [7:0]                alpha;
    logic                      complete;

    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || advance;
    assign process  = s1_valid_reg && advance;

    assign mag32 = shift_next[31] ? (32'd0 - shift_next) : shift_next;
    assign big   = mag32 > 32'(MAX_IMAGE_DIM);

    assign col_inc = col_reg + 1'b1;
    assign row_inc = row_reg + 1'b1;

    assign sx = w_neg_reg
        ? CW'(origin_x_reg) - CW'(w_mag_reg) - CW'(col_reg) - CW'(1)
        : CW'(origin_x_reg) + CW'(col_reg);
    assign sy = h_neg_reg
        ? CW'(origin_y_reg) + CW'(row_reg)
        : CW'(origin_y_reg) + CW'(h_mag_reg) - CW'(row_reg) - CW'(1);

    assign on_screen = !sx[CW-1] && (sx < CW'(SCREEN_WIDTH))
                    && !sy[CW-1] && (sy < CW'(SCREEN_HEIGHT));

    assign lin_addr = 32'(SCREEN_WIDTH) * 32'(sy[YW-1:0]) + 32'(sx[XW-1:0]);

    always_comb
    begin
        phase_t           ph;
        logic [OFF_W-1:0] off;
        logic [31:0]      sh;

        phase_next    = phase_reg;
        off_next      = off_reg;
        shift_next    = shift_reg;
        w_mag_next    = w_mag_reg;
        w_neg_next    = w_neg_reg;
        w_big_next    = w_big_reg;
        h_mag_next    = h_mag_reg;
        h_neg_next    = h_neg_reg;
        h_big_next    = h_big_reg;
        d24_next      = d24_reg;
        d32_next      = d32_reg;
        alpha_en_next = alpha_en_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        pad_next      = pad_reg;
        bip_next      = bip_reg;
        bgr_next      = bgr_reg;
        have          = 1'b0;
        pix_valid_next = 1'b0;
        addr_next     = '0;
        color_next    = '0;
        done_next     = 1'b0;
        status_next   = ST_OK;
        bgr_upd       = bgr_reg;
        alpha         = '0;
        complete      = 1'b0;

        ph  = s1_first_reg ? PH_HEADER : phase_reg;
        off = s1_first_reg ? '0 : off_reg;
        sh  = s1_first_reg ? '0 : shift_reg;

        phase_next = ph;
        off_next   = off;
        shift_next = sh;

        if (ph == PH_HEADER)
        begin
            shift_next = {s1_byte_reg, sh[31:8]};
            if (off == OFF_SIG && shift_next[31:16] != {SIG_HI, SIG_LO})
            begin
                phase_next  = PH_ERROR;
                have        = 1'b1;
                status_next = ST_NOT_BMP;
            end
            else if (off == OFF_WIDTH_END)
            begin
                w_mag_next = mag32[DIM_W-1:0];
                w_neg_next = shift_next[31];
                w_big_next = big;
            end
            else if (off == OFF_HEIGHT_END)
            begin
                h_mag_next = mag32[DIM_W-1:0];
                h_neg_next = shift_next[31];
                h_big_next = big;
            end
            else if (off == OFF_DEPTH_END)
            begin
                d24_next = shift_next[31:16] == DEPTH_24;
                d32_next = shift_next[31:16] == DEPTH_32;
            end
            if (phase_next == PH_HEADER)
            begin
                if (off >= HEADER_LAST)
                begin
                    if (!d24_reg && !d32_reg)
                    begin
                        phase_next  = PH_ERROR;
                        have        = 1'b1;
                        status_next = ST_BAD_DEPTH;
                    end
                    else if (w_big_reg || h_big_reg)
                    begin
                        phase_next  = PH_ERROR;
                        have        = 1'b1;
                        status_next = ST_TOO_LARGE;
                    end
                    else if (w_mag_reg == '0 || h_mag_reg == '0)
                    begin
                        phase_next = PH_DONE;
                        have       = 1'b1;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        alpha_en_next = d32_reg;
                        phase_next    = PH_PIXELS;
                        col_next      = '0;
                        row_next      = '0;
                        pad_next      = '0;
                        bip_next      = '0;
                        bgr_next      = '0;
                    end
                end
                else
                begin
                    off_next = off + 1'b1;
                end
            end
        end
        else if (ph == PH_PIXELS)
        begin
            if (pad_reg != '0)
            begin
                pad_next = pad_reg - 1'b1;
            end
            else
            begin
                if (bip_reg != 2'd3)
                begin
                    bgr_upd[8*bip_reg +: 8] = s1_byte_reg;
                    bgr_next = bgr_upd;
                    bip_next = bip_reg + 1'b1;
                    complete = (bip_reg == 2'd2) && !alpha_en_reg;
                end
                else
                begin
                    alpha    = s1_byte_reg;
                    complete = 1'b1;
                end
                if (complete)
                begin
                    have           = 1'b1;
                    color_next     = {alpha, bgr_upd};
                    pix_valid_next = on_screen;
                    addr_next      = on_screen ? lin_addr[ADDR_W-1:0] : '0;
                    bip_next       = '0;
                    bgr_next       = '0;
                    if (col_inc >= w_mag_reg)
                    begin
                        col_next = '0;
                        row_next = row_inc;
                        if (row_inc >= h_mag_reg)
                        begin
                            phase_next = PH_DONE;
                            done_next  = 1'b1;
                        end
                        else
                        begin
                            pad_next = alpha_en_reg ? 2'd0 : w_mag_reg[1:0];
                        end
                    end
                    else
                    begin
                        col_next = col_inc;
                    end
                end
            end
        end

        if ((ph == PH_HEADER || ph == PH_PIXELS) && s1_last_reg
            && (phase_next == PH_HEADER || phase_next == PH_PIXELS))
        begin
            phase_next  = PH_ERROR;
            have        = 1'b1;
            status_next = ST_TRUNCATED;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg  <= data_byte;
            s1_first_reg <= first_byte;
            s1_last_reg  <= last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            off_reg       <= '0;
            shift_reg     <= '0;
            w_mag_reg     <= '0;
            w_neg_reg     <= 1'b0;
            w_big_reg     <= 1'b0;
            h_mag_reg     <= '0;
            h_neg_reg     <= 1'b0;
            h_big_reg     <= 1'b0;
            d24_reg       <= 1'b0;
            d32_reg       <= 1'b0;
            alpha_en_reg  <= 1'b0;
            col_reg       <= '0;
            row_reg       <= '0;
            pad_reg       <= '0;
            bip_reg       <= '0;
            bgr_reg       <= '0;
            origin_x_reg  <= '0;
            origin_y_reg  <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pix_valid_reg <= 1'b0;
            addr_reg      <= '0;
            color_reg     <= '0;
            done_reg      <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_ORIGIN_X: origin_x_reg <= signed'(cfg_data);
                    CFG_ORIGIN_Y: origin_y_reg <= signed'(cfg_data);
                endcase
            end

            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end

            if (advance)
            begin
                out_valid_reg <= out_valid_next;
            end

            if (process)
            begin
                phase_reg    <= phase_next;
                off_reg      <= off_next;
                shift_reg    <= shift_next;
                w_mag_reg    <= w_mag_next;
                w_neg_reg    <= w_neg_next;
                w_big_reg    <= w_big_next;
                h_mag_reg    <= h_mag_next;
                h_neg_reg    <= h_neg_next;
                h_big_reg    <= h_big_next;
                d24_reg      <= d24_next;
                d32_reg      <= d32_next;
                alpha_en_reg <= alpha_en_next;
                col_reg      <= col_next;
                row_reg      <= row_next;
                pad_reg      <= pad_next;
                bip_reg      <= bip_next;
                bgr_reg      <= bgr_next;
                if (have)
                begin
                    pix_valid_reg <= pix_valid_next;
                    addr_reg      <= addr_next;
                    color_reg     <= color_next;
                    done_reg      <= done_next;
                    status_reg    <= status_next;
                end
            end
        end
    end

    assign out_valid_next = process && have;

    assign out_valid   = out_valid_reg;
    assign pixel_valid = pix_valid_reg;
    assign pixel_addr  = addr_reg;
    assign pixel_color = color_reg;
    assign image_done  = done_reg;
    assign status      = status_reg;

endmodule

[rtl/bsfb_checker.sv]
module bsfb_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              out_valid,
    input logic                              out_ready,
    input logic                              pixel_valid,
    input logic [bsfb_pkg::ADDR_W-1:0]       pixel_addr,
    input logic [bsfb_pkg::COLOR_W-1:0]      pixel_color,
    input logic                              image_done,
    input logic [bsfb_pkg::STATUS_W-1:0]     status
);
    import bsfb_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_valid)
            && $stable(pixel_addr) && $stable(pixel_color)
            && $stable(image_done) && $stable(status))
        else $error("stalled result changed");

    a_clip_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pixel_valid |-> pixel_addr == '0)
        else $error("clipped or non-pixel result carries an address");

    a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && image_done |-> status == ST_OK)
        else $error("image done with error status");

    a_error_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ST_NOT_BMP || status == ST_BAD_DEPTH
            || status == ST_TOO_LARGE)
        |-> !pixel_valid && pixel_color == '0 && !image_done)
        else $error("header error result carries pixel data");

endmodule

bind bmp_stream_to_framebuffer_top bsfb_checker u_bsfb_checker (.*);
